// ===== src/isc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isc_pkg
// Types and constants shared by the ceiling square root controller and
// datapath.
// ----------------------------------------------------------------------------
package isc_pkg;

   localparam int unsigned OperandWidth = 32;
   localparam int unsigned RootWidth    = 16;
   localparam int unsigned RemWidth     = RootWidth + 1;
   localparam int unsigned StepCount    = OperandWidth / 2;
   localparam int unsigned StepCntWidth = $clog2(StepCount);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_ADJUST
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic adjust;
   } cmd_type;

endpackage

// ===== src/isc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isc_ctrl
// Sequencer for the ceiling square root: loads a word, runs one digit step
// per cycle and writes the adjusted root to the output register.
// ----------------------------------------------------------------------------
module isc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output isc_pkg::cmd_type cmd
);

   isc_pkg::state_type                     state_ff, state_in;
   logic [isc_pkg::StepCntWidth-1:0]       cnt_ff, cnt_in;
   logic                                   out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= isc_pkg::ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         isc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = isc_pkg::ST_RUN;
            end
         end
         isc_pkg::ST_RUN: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == isc_pkg::StepCntWidth'(isc_pkg::StepCount - 1)) begin
               state_in = isc_pkg::ST_ADJUST;
            end
         end
         isc_pkg::ST_ADJUST: begin
            // hold while the previous word still waits
            if (!(out_valid_ff && rsp_stall)) begin
               cmd.adjust   = 1'b1;
               out_valid_in = 1'b1;
               state_in     = isc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = isc_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = out_valid_ff;

endmodule

// ===== src/isc_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isc_dpath
// Restoring digit-by-digit root: operand shift register, partial remainder,
// root accumulator and the ceiling adjust into the output register.
// ----------------------------------------------------------------------------
module isc_dpath (
   input  logic                                clock,
   input  isc_pkg::cmd_type                    cmd,
   input  logic signed [isc_pkg::OperandWidth-1:0] req_value,
   output logic [isc_pkg::RootWidth-1:0]       rsp_root_ceiling
);

   logic [isc_pkg::OperandWidth-1:0] rad_ff, rad_in;
   logic [isc_pkg::RemWidth-1:0]     rem_ff, rem_in;
   logic [isc_pkg::RootWidth-1:0]    root_ff, root_in;
   logic                             zero_ff, zero_in;
   logic [isc_pkg::RootWidth-1:0]    out_ff, out_in;
   logic [isc_pkg::RemWidth+1:0]     rem_sh;
   logic [isc_pkg::RemWidth+1:0]     trial;

   always_comb begin
      rem_sh  = {rem_ff, rad_ff[isc_pkg::OperandWidth-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      zero_in = zero_ff;
      out_in  = out_ff;
      if (cmd.load) begin
         rad_in  = req_value;
         rem_in  = '0;
         root_in = '0;
         zero_in = req_value[isc_pkg::OperandWidth-1] || (req_value == '0);
      end
      if (cmd.step) begin
         rad_in = {rad_ff[isc_pkg::OperandWidth-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = isc_pkg::RemWidth'(rem_sh - trial);
            root_in = {root_ff[isc_pkg::RootWidth-2:0], 1'b1};
         end else begin
            rem_in  = isc_pkg::RemWidth'(rem_sh);
            root_in = {root_ff[isc_pkg::RootWidth-2:0], 1'b0};
         end
      end
      if (cmd.adjust) begin
         if (zero_ff) begin
            out_in = '0;
         end else begin
            out_in = root_ff + isc_pkg::RootWidth'(rem_ff != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      zero_ff <= zero_in;
      out_ff  <= out_in;
   end

   assign rsp_root_ceiling = out_ff;

endmodule

// ===== src/integer_sqrt_ceiling_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_sqrt_ceiling_top
// Ceiling square root of a signed 32-bit word.
// ----------------------------------------------------------------------------
// Each request word gives one response word: the least r with r*r at least
// the operand, 0 for zero or negative operands. The operand is loaded at the
// edge that accepts it. It then passes through sixteen digit steps of the
// restoring root unit (one root bit per cycle) and the ceiling adjust into the
// output register; the adjust is held while a previous result still waits. The
// request side then takes the next word in the idle cycle that follows. A
// new word is taken once the previous one has reached the output register,
// so the next word may start while a result still waits.
module integer_sqrt_ceiling_top (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [isc_pkg::OperandWidth-1:0]  req_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [isc_pkg::RootWidth-1:0]            rsp_root_ceiling
);

   isc_pkg::cmd_type cmd;

   isc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   isc_dpath u_dpath (
      .clock            (clock),
      .cmd              (cmd),
      .req_value        (req_value),
      .rsp_root_ceiling (rsp_root_ceiling)
   );

endmodule
